@@ src/vcorr_pkg.sv @@
`timescale 1ns / 1ps
package vcorr_pkg;

    localparam int KSIDE     = 8;
    localparam int KIDX_W    = $clog2(KSIDE);
    localparam int IMG_W     = 1024;
    localparam int IMG_H     = 1024;
    localparam int COL_W     = $clog2(IMG_W);
    localparam int ROW_W     = $clog2(IMG_H);
    localparam int LINE_ROWS = KSIDE - 1;
    localparam int SLOT_W    = $clog2(LINE_ROWS);
    localparam int SMP_W     = 16;
    localparam int PROD_W    = 2 * SMP_W;
    localparam int PSUM_W    = PROD_W + $clog2(KSIDE);
    localparam int SUM_W     = 38;

    typedef logic signed [SMP_W-1:0] t_sample;
    typedef t_sample t_col [KSIDE];

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_KERNEL_WIDTH  = 2'd2,
        REG_KERNEL_HEIGHT = 2'd3
    } t_reg_idx;

    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic adv;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic             emit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

endpackage

@@ src/vcorr_ram.sv @@
`timescale 1ns / 1ps
module vcorr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/vcorr_cell.sv @@
`timescale 1ns / 1ps
module vcorr_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vcorr_pkg::t_cell_ctl                i_ctl,
    input  vcorr_pkg::t_col                     i_col,
    input  vcorr_pkg::t_col                     i_coef,
    output vcorr_pkg::t_col                     o_col,
    output logic signed [vcorr_pkg::PSUM_W-1:0] o_psum
);
    vcorr_pkg::t_col r_win;
    logic signed [vcorr_pkg::PROD_W-1:0] r_prod [vcorr_pkg::KSIDE];
    logic signed [vcorr_pkg::PSUM_W-1:0] r_psum;
    logic signed [vcorr_pkg::PSUM_W-1:0] n_psum;

    // hold one window column; take the neighbour's column on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < vcorr_pkg::KSIDE; k++) r_win[k] <= '0;
        end else if (i_ctl.adv && i_ctl.shift) begin
            for (int k = 0; k < vcorr_pkg::KSIDE; k++) r_win[k] <= i_col[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            for (int k = 0; k < vcorr_pkg::KSIDE; k++) r_prod[k] <= r_win[k] * i_coef[k];
            r_psum <= n_psum;
        end
    end

    always_comb begin
        n_psum = '0;
        for (int k = 0; k < vcorr_pkg::KSIDE; k++) begin
            n_psum = n_psum + vcorr_pkg::PSUM_W'(r_prod[k]);
        end
    end

    assign o_col  = r_win;
    assign o_psum = r_psum;
endmodule

@@ src/valid_2d_correlation.sv @@
`timescale 1ns / 1ps
// Channel   | Dir | Handshake                | Payload
// s_axis    | in  | i_s_tvalid / o_s_tready  | tdata: coef_row, coef_col, value; tuser: op
// m_axis    | out | o_m_tvalid / i_m_tready  | tdata: sum, out_row, out_col; tlast: is_last
// cfg       | in  | i_cfg_valid / o_cfg_ready| addr: register index; data: value
//
// One item per clock in steady state, unless a stalled result holds the pipeline.
// A result passes the line store read, the window shift, the product register and the
// partial sum register, with the final adder feeding the output register.
// The whole pipeline advances together whenever the output register is free or taken,
// so a stalled result holds every stage and the input ready drops with it.
// Synchronous active-low reset clears counters, window, coefficients and valid bits;
// the line store is not cleared and needs no sweep.
module valid_2d_correlation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // [2:0] coef_row, [5:3] coef_col, [21:6] value, rest zero
    input  logic [0:0]  i_s_tuser,  // [0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,  // [37:0] sum, [47:38] out_row, [57:48] out_col, rest zero
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [10:0] i_cfg_data
);
    localparam int K  = vcorr_pkg::KSIDE;
    localparam int CW = vcorr_pkg::COL_W;
    localparam int RW = vcorr_pkg::ROW_W;
    localparam int SW = vcorr_pkg::SLOT_W;

    // configuration registers
    logic [10:0] r_img_w, r_img_h;
    logic [3:0]  r_ker_w, r_ker_h;
    logic [10:0] w, h;
    logic [3:0]  kw, kh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 11'd8;
            r_img_h <= 11'd8;
            r_ker_w <= 4'd3;
            r_ker_h <= 4'd3;
        end else if (i_cfg_valid) begin
            unique case (vcorr_pkg::t_reg_idx'(i_cfg_addr))
                vcorr_pkg::REG_IMAGE_WIDTH:   r_img_w <= i_cfg_data;
                vcorr_pkg::REG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data;
                vcorr_pkg::REG_KERNEL_WIDTH:  r_ker_w <= i_cfg_data[3:0];
                vcorr_pkg::REG_KERNEL_HEIGHT: r_ker_h <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // clamp every register to its legal range; zero counts as one
    always_comb begin
        w  = (r_img_w == '0) ? 11'd1 : ((r_img_w > 11'(vcorr_pkg::IMG_W)) ?
             11'(vcorr_pkg::IMG_W) : r_img_w);
        h  = (r_img_h == '0) ? 11'd1 : ((r_img_h > 11'(vcorr_pkg::IMG_H)) ?
             11'(vcorr_pkg::IMG_H) : r_img_h);
        kw = (r_ker_w == '0) ? 4'd1 : ((r_ker_w > 4'(K)) ? 4'(K) : r_ker_w);
        kh = (r_ker_h == '0) ? 4'd1 : ((r_ker_h > 4'(K)) ? 4'(K) : r_ker_h);
    end

    // input field unpacking
    logic                     in_op;
    logic [2:0]               in_crow, in_ccol;
    vcorr_pkg::t_sample       in_val;
    assign in_crow = i_s_tdata[2:0];
    assign in_ccol = i_s_tdata[5:3];
    assign in_val  = i_s_tdata[21:6];
    assign in_op   = i_s_tuser[0];

    logic adv, acc, acc_pix;
    logic r_out_valid;
    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = adv;
    assign acc        = i_s_tvalid && adv;
    assign acc_pix    = acc && (in_op == vcorr_pkg::OP_PIXEL);

    // raster counters; the row slot tracks row modulo the number of stored rows
    logic [CW-1:0] r_col_cnt;
    logic [RW-1:0] r_row_cnt;
    logic [SW-1:0] r_row_slot;
    logic          col_wrap, row_wrap;

    assign col_wrap = ({1'b0, r_col_cnt} + 11'd1) >= w;
    assign row_wrap = ({1'b0, r_row_cnt} + 11'd1) >= h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_row_slot <= '0;
        end else if (acc_pix) begin
            if (col_wrap) begin
                r_col_cnt <= '0;
                if (row_wrap) begin
                    r_row_cnt  <= '0;
                    r_row_slot <= '0;
                end else begin
                    r_row_cnt  <= r_row_cnt + 1'b1;
                    r_row_slot <= (r_row_slot == SW'(vcorr_pkg::LINE_ROWS - 1)) ?
                                  '0 : r_row_slot + 1'b1;
                end
            end else begin
                r_col_cnt <= r_col_cnt + 1'b1;
            end
        end
    end

    // window position and line store slot selection for the incoming sample
    vcorr_pkg::t_meta n_meta;
    logic [SW-1:0]    n_sel [K];
    logic [K-1:0]     n_ok;
    logic [3:0]       back;
    logic [3:0]       t;

    always_comb begin
        n_meta.emit = ({7'b0, kw} <= w) && ({7'b0, kh} <= h) &&
                      (({1'b0, r_col_cnt} + 11'd1) >= {7'b0, kw}) &&
                      (({1'b0, r_row_cnt} + 11'd1) >= {7'b0, kh}) &&
                      ({1'b0, r_col_cnt} < w) && ({1'b0, r_row_cnt} < h);
        n_meta.row  = r_row_cnt - RW'(kh) + RW'(1);
        n_meta.col  = r_col_cnt - CW'(kw) + CW'(1);
        n_meta.last = ({1'b0, r_row_cnt} == h - 11'd1) && ({1'b0, r_col_cnt} == w - 11'd1);
        back = '0;
        t    = '0;
        for (int kr = 0; kr < K; kr++) begin
            back     = kh - 4'd1 - 4'(kr);
            n_ok[kr] = (4'(kr + 1) < kh) && ({6'b0, back} <= r_row_cnt);
            t        = {1'b0, r_row_slot} + 4'(vcorr_pkg::LINE_ROWS) - back;
            if (t >= 4'(vcorr_pkg::LINE_ROWS)) begin
                t = t - 4'(vcorr_pkg::LINE_ROWS);
            end
            n_sel[kr] = t[SW-1:0];
        end
    end

    // line store: one memory per stored row
    vcorr_pkg::t_sample ram_q [vcorr_pkg::LINE_ROWS];

    for (genvar s = 0; s < vcorr_pkg::LINE_ROWS; s++) begin : g_line
        vcorr_ram #(
            .WIDTH(vcorr_pkg::SMP_W),
            .DEPTH(vcorr_pkg::IMG_W)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (acc_pix && (r_row_slot == SW'(s))),
            .i_waddr(r_col_cnt),
            .i_wdata(in_val),
            .i_re   (adv),
            .i_raddr(r_col_cnt),
            .o_rdata(ram_q[s])
        );
    end

    // stage 1: item waits for its line store read
    logic               r1_vld, r1_pix;
    vcorr_pkg::t_sample r1_val;
    logic [2:0]         r1_crow, r1_ccol, r1_top;
    logic [SW-1:0]      r1_sel [K];
    logic [K-1:0]       r1_ok;
    vcorr_pkg::t_meta   r1_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_pix  <= in_op;
            r1_val  <= in_val;
            r1_crow <= in_crow;
            r1_ccol <= in_ccol;
            r1_top  <= 3'(kh - 4'd1);
            r1_sel  <= n_sel;
            r1_ok   <= n_ok;
            r1_meta <= n_meta;
        end
    end

    // coefficients, loaded in order with the samples around them
    vcorr_pkg::t_sample r_coef [K][K];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < K; a++)
                for (int b = 0; b < K; b++) r_coef[a][b] <= '0;
        end else if (adv && r1_vld && (r1_pix == vcorr_pkg::OP_COEF)) begin
            r_coef[r1_crow][r1_ccol] <= r1_val;
        end
    end

    // assemble the newest column: stored rows above, the sample at the kernel bottom
    vcorr_pkg::t_col new_col;
    always_comb begin
        for (int kr = 0; kr < K; kr++) begin
            if (3'(kr) == r1_top)  new_col[kr] = r1_val;
            else if (r1_ok[kr])    new_col[kr] = ram_q[r1_sel[kr]];
            else                   new_col[kr] = '0;
        end
    end

    // chain of cells: cell K-1 takes the new column, each passes its column left
    vcorr_pkg::t_cell_ctl ctl;
    vcorr_pkg::t_col      cell_in   [K];
    vcorr_pkg::t_col      cell_out  [K];
    vcorr_pkg::t_col      cell_coef [K];
    logic signed [vcorr_pkg::PSUM_W-1:0] psum [K];

    assign ctl.adv   = adv;
    assign ctl.shift = r1_vld && (r1_pix == vcorr_pkg::OP_PIXEL);

    for (genvar j = 0; j < K; j++) begin : g_cell
        if (j == K - 1) begin : g_head
            assign cell_in[j] = new_col;
        end else begin : g_body
            assign cell_in[j] = cell_out[j+1];
        end

        // cell j lines up with kernel column j + kw - K; rows past kh drop out
        always_comb begin
            for (int kr = 0; kr < K; kr++) begin
                if ((5'(j) + 5'(kw) >= 5'(K)) && (4'(kr) < kh))
                    cell_coef[j][kr] = r_coef[kr][3'(j + int'(kw) - K)];
                else
                    cell_coef[j][kr] = '0;
            end
        end

        vcorr_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl),
            .i_col  (cell_in[j]),
            .i_coef (cell_coef[j]),
            .o_col  (cell_out[j]),
            .o_psum (psum[j])
        );
    end

    // result tags travel alongside the product and partial sum stages
    vcorr_pkg::t_meta r2_meta, r3_meta, r4_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_meta.emit <= 1'b0;
            r3_meta.emit <= 1'b0;
            r4_meta.emit <= 1'b0;
        end else if (adv) begin
            r2_meta.emit <= r1_vld && (r1_pix == vcorr_pkg::OP_PIXEL) && r1_meta.emit;
            r3_meta.emit <= r2_meta.emit;
            r4_meta.emit <= r3_meta.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            {r2_meta.row, r2_meta.col, r2_meta.last} <= {r1_meta.row, r1_meta.col, r1_meta.last};
            {r3_meta.row, r3_meta.col, r3_meta.last} <= {r2_meta.row, r2_meta.col, r2_meta.last};
            {r4_meta.row, r4_meta.col, r4_meta.last} <= {r3_meta.row, r3_meta.col, r3_meta.last};
        end
    end

    // final adder and output register
    logic signed [vcorr_pkg::SUM_W-1:0] n_sum, r_sum;
    vcorr_pkg::t_meta r_out_meta;

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < K; j++) n_sum = n_sum + vcorr_pkg::SUM_W'(psum[j]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r4_meta.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum      <= n_sum;
            r_out_meta <= r4_meta;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_meta.col, r_out_meta.row, r_sum};
    assign o_m_tlast  = r_out_meta.last;

`ifndef ASSERT_OFF
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_slot < SW'(vcorr_pkg::LINE_ROWS))
        else $error("row slot out of range");
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_pix && col_wrap |=> r_col_cnt == '0)
        else $error("column counter did not wrap");
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |->
            ({1'b0, r_out_meta.col} == w - {7'b0, kw}) &&
            ({1'b0, r_out_meta.row} == h - {7'b0, kh}))
        else $error("last result not at frame corner");
`endif
endmodule
